[design/pwt_pkg.sv]
// shared types and codes for the protobuf wire tokenizer
package pwt_pkg;

    // token kinds
    localparam logic [2:0] KIND_TAG     = 3'd0;
    localparam logic [2:0] KIND_VARINT  = 3'd1;
    localparam logic [2:0] KIND_FIXED64 = 3'd2;
    localparam logic [2:0] KIND_LENGTH  = 3'd3;
    localparam logic [2:0] KIND_PAYLOAD = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // error codes
    localparam logic [2:0] ERR_WIRE_TYPE   = 3'd0;
    localparam logic [2:0] ERR_VARINT_LONG = 3'd1;
    localparam logic [2:0] ERR_LENGTH      = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
    localparam logic [2:0] ERR_FIELD_LARGE = 3'd4;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;

    localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [28:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic        last_of_payload;
        logic [2:0]  error_code;
        logic        last_of_step;
    } out_word_t;

endpackage

[design/protobuf_wire_tokenizer.sv]
// protobuf wire format tokenizer: byte in, tag/value/length/payload/error words out
//
// One byte of an encoded buffer is taken per word on the src channel. Each byte
// updates the parse state in the cycle it is accepted and yields zero, one or two
// result words, which are written into a four-entry result queue and appear on the
// tok channel from the next cycle on. A byte is taken whenever the queue has at
// least two free entries, so with tok_ready held high the block takes one byte
// every cycle as long as each byte yields at most one word; a byte that yields two
// words (a tag followed by an error, or a token followed by a truncation error)
// leaves one word more in the queue, since the tok port drains one word per cycle.
// After a fault the block keeps taking bytes silently until the byte marked
// end_of_buffer; every such byte returns the parser to its reset state. max_length
// is written through the cfg channel, which is always ready, and must only be written
// while the block is idle.
module protobuf_wire_tokenizer (
    input  logic              clk,
    input  logic              rst_n,
    // config write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data,
    // input bytes
    input  logic              src_valid,
    output logic              src_ready,
    input  pwt_pkg::in_word_t src_data,
    // result words
    output logic              tok_valid,
    input  logic              tok_ready,
    output pwt_pkg::out_word_t tok_data
);
    import pwt_pkg::*;

    // parser phases
    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_TAGCONT = 3'd1;
    localparam logic [2:0] PH_VARINT  = 3'd2;
    localparam logic [2:0] PH_FIXED   = 3'd3;
    localparam logic [2:0] PH_LENGTH  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QPTRW  = $clog2(QDEPTH);

    // configuration
    logic [31:0] max_length_reg;

    // parse state
    logic [2:0]  phase_reg,   phase_next;
    logic [63:0] acc_reg,     acc_next;
    logic [3:0]  bcnt_reg,    bcnt_next;
    logic [28:0] field_reg,   field_next;
    logic [2:0]  wtype_reg,   wtype_next;
    logic [31:0] left_reg,    left_next;
    logic        in_err_reg,  in_err_next;

    // result queue
    out_word_t        q_reg [QDEPTH];
    logic [QPTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTRW:0]   count_reg, count_next;

    // step logic
    logic        accept, pop;
    logic [7:0]  b;
    logic        eob, cont;
    logic [6:0]  part;
    logic        tok_emit;
    out_word_t   tok_w;
    logic        flt_req;
    logic [2:0]  flt_code;
    logic [28:0] flt_field;
    logic [2:0]  flt_wt;
    logic [63:0] flt_val;
    logic        finish_tag;
    logic [4:0]  tshift;
    logic [6:0]  vshift;
    logic [63:0] len_v;
    logic [63:0] tag_v;
    out_word_t   flt_w, res0, res1;
    logic [1:0]  nres;

    function automatic out_word_t make_tok(
        input logic [2:0]  kind,
        input logic [28:0] fld,
        input logic [2:0]  wt,
        input logic [63:0] val,
        input logic        lastp,
        input logic [2:0]  code
    );
        out_word_t w;
        w.token_kind      = kind;
        w.field_number    = fld;
        w.wire_type       = wt;
        w.value           = val;
        w.last_of_payload = lastp;
        w.error_code      = code;
        w.last_of_step    = 1'b0;
        return w;
    endfunction

    assign cfg_ready = 1'b1;
    // room for the two words one byte may cause
    assign src_ready = (count_reg <= (QPTRW+1)'(QDEPTH - 2));
    assign accept    = src_valid && src_ready;
    assign tok_valid = (count_reg != '0);
    assign tok_data  = q_reg[rd_ptr_reg];
    assign pop       = tok_valid && tok_ready;

    assign b    = src_data.data_byte;
    assign eob  = src_data.end_of_buffer;
    assign cont = b[7];
    assign part = b[6:0];

    // byte step: at most one regular token, then at most one fault
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        bcnt_next   = bcnt_reg;
        field_next  = field_reg;
        wtype_next  = wtype_reg;
        left_next   = left_reg;
        in_err_next = in_err_reg;
        tok_emit    = 1'b0;
        tok_w       = make_tok(KIND_TAG, '0, '0, '0, 1'b0, ERR_WIRE_TYPE);
        flt_req     = 1'b0;
        flt_code    = ERR_WIRE_TYPE;
        flt_field   = '0;
        flt_wt      = wtype_reg;
        flt_val     = '0;
        finish_tag  = 1'b0;
        tshift      = '0;
        vshift      = 7'(bcnt_reg) * 7'd7;
        len_v       = '0;
        tag_v       = '0;

        if (accept && !in_err_reg)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    wtype_next = b[2:0];
                    acc_next   = {60'd0, b[6:3]};
                    bcnt_next  = 4'd1;
                    if (cont)
                    begin
                        phase_next = PH_TAGCONT;
                        if (eob)
                        begin
                            flt_req  = 1'b1;
                            flt_code = ERR_TRUNCATED;
                        end
                    end
                    else
                    begin
                        finish_tag = 1'b1;
                    end
                end
                PH_TAGCONT:
                begin
                    // field bits beyond 29 only matter as "too large"
                    if (bcnt_reg >= 4'd5)
                    begin
                        if (part != '0)
                            acc_next = '1;
                    end
                    else
                    begin
                        unique case (bcnt_reg[1:0])
                            2'd1:    tshift = 5'd4;
                            2'd2:    tshift = 5'd11;
                            2'd3:    tshift = 5'd18;
                            default: tshift = 5'd25;
                        endcase
                        acc_next = acc_reg | (64'(part) << tshift);
                    end
                    if (cont)
                    begin
                        flt_req = 1'b1;
                        if (bcnt_reg >= 4'd9)
                        begin
                            flt_code = ERR_VARINT_LONG;
                        end
                        else
                        begin
                            bcnt_next = bcnt_reg + 4'd1;
                            flt_req   = eob;
                            flt_code  = ERR_TRUNCATED;
                        end
                    end
                    else
                    begin
                        finish_tag = 1'b1;
                    end
                end
                PH_VARINT, PH_LENGTH:
                begin
                    if (vshift < 7'd64)
                        acc_next = acc_reg | (64'(part) << vshift[5:0]);
                    flt_field = field_reg;
                    if (cont)
                    begin
                        flt_req = 1'b1;
                        if (bcnt_reg >= 4'd9)
                        begin
                            flt_code = ERR_VARINT_LONG;
                        end
                        else
                        begin
                            bcnt_next = bcnt_reg + 4'd1;
                            flt_req   = eob;
                            flt_code  = ERR_TRUNCATED;
                        end
                    end
                    else if (phase_reg == PH_VARINT)
                    begin
                        tok_emit   = 1'b1;
                        tok_w      = make_tok(KIND_VARINT, field_reg, wtype_reg, acc_next,
                                              1'b0, ERR_WIRE_TYPE);
                        acc_next   = '0;
                        bcnt_next  = '0;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        len_v     = acc_next;
                        acc_next  = '0;
                        bcnt_next = '0;
                        if (len_v > {32'd0, max_length_reg})
                        begin
                            flt_req  = 1'b1;
                            flt_code = ERR_LENGTH;
                            flt_val  = len_v;
                        end
                        else
                        begin
                            tok_emit = 1'b1;
                            tok_w    = make_tok(KIND_LENGTH, field_reg, wtype_reg, len_v,
                                                1'b0, ERR_WIRE_TYPE);
                            if (len_v == '0)
                            begin
                                phase_next = PH_TAG;
                            end
                            else
                            begin
                                left_next  = len_v[31:0];
                                phase_next = PH_PAYLOAD;
                                flt_req    = eob;
                                flt_code   = ERR_TRUNCATED;
                            end
                        end
                    end
                end
                PH_FIXED:
                begin
                    acc_next  = acc_reg | (64'(b) << {bcnt_reg[2:0], 3'b000});
                    flt_field = field_reg;
                    if (bcnt_reg >= 4'd7)
                    begin
                        tok_emit   = 1'b1;
                        tok_w      = make_tok(KIND_FIXED64, field_reg, wtype_reg, acc_next,
                                              1'b0, ERR_WIRE_TYPE);
                        acc_next   = '0;
                        bcnt_next  = '0;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        bcnt_next = bcnt_reg + 4'd1;
                        flt_req   = eob;
                        flt_code  = ERR_TRUNCATED;
                    end
                end
                PH_PAYLOAD:
                begin
                    tok_emit  = 1'b1;
                    tok_w     = make_tok(KIND_PAYLOAD, field_reg, wtype_reg, 64'(b),
                                         (left_reg <= 32'd1), ERR_WIRE_TYPE);
                    flt_field = field_reg;
                    if (left_reg <= 32'd1)
                    begin
                        left_next  = '0;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        left_next = left_reg - 32'd1;
                        flt_req   = eob;
                        flt_code  = ERR_TRUNCATED;
                    end
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase

            // end of a tag varint: check field, emit tag, pick value phase
            if (finish_tag)
            begin
                tag_v     = acc_next;
                acc_next  = '0;
                bcnt_next = '0;
                if (tag_v[63:29] != '0)
                begin
                    flt_req   = 1'b1;
                    flt_code  = ERR_FIELD_LARGE;
                    flt_field = '0;
                end
                else
                begin
                    field_next = tag_v[28:0];
                    tok_emit   = 1'b1;
                    tok_w      = make_tok(KIND_TAG, field_next, wtype_next, '0, 1'b0,
                                          ERR_WIRE_TYPE);
                    flt_field  = field_next;
                    if (wtype_next > WT_LEN)
                    begin
                        flt_req  = 1'b1;
                        flt_code = ERR_WIRE_TYPE;
                    end
                    else
                    begin
                        unique case (wtype_next)
                            WT_VARINT:  phase_next = PH_VARINT;
                            WT_FIXED64: phase_next = PH_FIXED;
                            default:    phase_next = PH_LENGTH;
                        endcase
                        flt_req  = eob;
                        flt_code = ERR_TRUNCATED;
                    end
                end
            end

            // error words carry the wire type of this step, before any end of buffer
            flt_wt = wtype_next;

            if (flt_req)
                in_err_next = 1'b1;
        end

        // every end of buffer brings the parser back to its reset state
        if (accept && eob)
        begin
            phase_next  = PH_TAG;
            acc_next    = '0;
            bcnt_next   = '0;
            field_next  = '0;
            wtype_next  = '0;
            left_next   = '0;
            in_err_next = 1'b0;
        end
    end

    // pack the step's words: regular token first, fault after it
    always_comb
    begin
        flt_w = make_tok(KIND_ERROR, flt_field, flt_wt, flt_val, 1'b0, flt_code);
        res0  = tok_emit ? tok_w : flt_w;
        res1  = flt_w;
        nres  = 2'(tok_emit) + 2'(flt_req);
        if (nres == 2'd1)
            res0.last_of_step = 1'b1;
        res1.last_of_step = 1'b1;
    end

    assign count_next = count_reg + (QPTRW+1)'(nres) - (QPTRW+1)'(pop);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
            phase_reg      <= PH_TAG;
            acc_reg        <= '0;
            bcnt_reg       <= '0;
            field_reg      <= '0;
            wtype_reg      <= '0;
            left_reg       <= '0;
            in_err_reg     <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_length_reg <= cfg_data;
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            bcnt_reg   <= bcnt_next;
            field_reg  <= field_next;
            wtype_reg  <= wtype_next;
            left_reg   <= left_next;
            in_err_reg <= in_err_next;
            wr_ptr_reg <= wr_ptr_reg + QPTRW'(nres);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTRW'(1);
            count_reg  <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (nres != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (nres == 2'd2)
            q_reg[wr_ptr_reg + QPTRW'(1)] <= res1;
    end

endmodule
